>>> rtl/core/apl_pkg.sv
// Shared constants, types and helper functions of the antenna pattern loss map.
package apl_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int MAX_DIM       = 4096;

	// Root extraction retires one result bit per stage.
	localparam int SQ_STAGES = 28;
	localparam int SQ_W      = 2 * SQ_STAGES;

	localparam int ANG_W = 17;
	localparam logic [ANG_W-1:0] TURN          = 17'd92160;
	localparam logic [ANG_W-1:0] HALF_TURN     = 17'd46080;
	localparam logic [ANG_W-1:0] QUARTER       = 17'd23040;
	localparam logic [ANG_W-1:0] THREE_QUARTER = 17'd69120;

	// Angle accumulator in 1/65536 degree.
	localparam int Z_W = 27;
	localparam logic signed [Z_W-1:0] Z_HALF = Z_W'(180 * 65536);

	localparam int CX_W = 28;
	localparam int EX_W = 31;

	localparam int TBL_DEPTH = 360;
	localparam int TBL_AW    = 9;

	localparam int DIV90_SH = 28;
	localparam logic [21:0] DIV90_M = 22'((1 << DIV90_SH) / 90);

	localparam logic [1:0] KIND_LOAD_H = 2'd0;
	localparam logic [1:0] KIND_LOAD_V = 2'd1;
	localparam logic [1:0] KIND_PIXEL  = 2'd2;

	localparam logic [2:0] CFG_EAST_OFFSET   = 3'd0;
	localparam logic [2:0] CFG_NORTH_OFFSET  = 3'd1;
	localparam logic [2:0] CFG_COL_STEP      = 3'd2;
	localparam logic [2:0] CFG_ROW_STEP      = 3'd3;
	localparam logic [2:0] CFG_RADIUS        = 3'd4;
	localparam logic [2:0] CFG_HEIGHT_OFFSET = 3'd5;
	localparam logic [2:0] CFG_AZIMUTH       = 3'd6;
	localparam logic [2:0] CFG_DOWNTILT      = 3'd7;

	typedef struct packed {
		logic [31:0] east_offset;
		logic [31:0] north_offset;
		logic [15:0] col_step;
		logic [15:0] row_step;
		logic [23:0] radius;
		logic [19:0] height_offset;
		logic [8:0]  azimuth;
		logic [7:0]  downtilt;
	} apl_cfg_t;

	// Fields that ride along with every word.
	typedef struct packed {
		logic [1:0]  kind;
		logic [8:0]  tidx;
		logic [15:0] tval;
		logic [15:0] pl;
		logic        nd;
	} apl_tag_t;

	typedef struct packed {
		apl_tag_t    tag;
		logic [24:0] de;
		logic [24:0] dn;
		logic [47:0] dsq;
		logic [24:0] hgt;
	} apl_geo_t;

	typedef struct packed {
		apl_tag_t          tag;
		logic [ANG_W-1:0]  hd;
		logic [27:0]       rng;
		logic [24:0]       hgt;
	} apl_ang_t;

	typedef struct packed {
		apl_tag_t          tag;
		logic [ANG_W-1:0]  hd;
		logic [ANG_W-1:0]  vd;
	} apl_vd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        nd;
		logic [17:0] loss;
	} apl_res_t;

	// atan(2^-i) in 1/65536 degree
	function automatic logic signed [Z_W-1:0] atan_lut(input int unsigned i);
		logic signed [Z_W-1:0] r;
		case (i)
			0:  r = Z_W'(2949120);
			1:  r = Z_W'(1740967);
			2:  r = Z_W'(919879);
			3:  r = Z_W'(466945);
			4:  r = Z_W'(234379);
			5:  r = Z_W'(117304);
			6:  r = Z_W'(58666);
			7:  r = Z_W'(29335);
			8:  r = Z_W'(14668);
			9:  r = Z_W'(7334);
			10: r = Z_W'(3667);
			11: r = Z_W'(1833);
			12: r = Z_W'(917);
			13: r = Z_W'(458);
			14: r = Z_W'(229);
			15: r = Z_W'(115);
			16: r = Z_W'(57);
			17: r = Z_W'(29);
			18: r = Z_W'(14);
			19: r = Z_W'(7);
			20: r = Z_W'(4);
			21: r = Z_W'(2);
			22: r = Z_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

	// Fold an angle within one turn of the range back into [0, TURN).
	function automatic logic [ANG_W-1:0] angle_wrap(input logic signed [19:0] a);
		logic signed [19:0] t;
		logic signed [19:0] turn_s;
		turn_s = $signed({3'b000, TURN});
		if (a < 0) begin
			t = a + turn_s;
		end else if (a >= turn_s) begin
			t = a - turn_s;
		end else begin
			t = a;
		end
		return t[ANG_W-1:0];
	endfunction

	// Round a 1/65536 degree accumulator to 1/256 degree.
	function automatic logic signed [19:0] z_round(input logic signed [Z_W-1:0] z);
		logic signed [Z_W-1:0] t;
		t = (z + Z_W'(128)) >>> 8;
		return t[19:0];
	endfunction

endpackage

>>> rtl/core/apl_front.sv
// Cell geometry: offsets to the transmitter, squared distance and radius test.
module apl_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  apl_pkg::apl_cfg_t cfg,
	input  logic              in_v,
	input  logic [1:0]        kind,
	input  logic [8:0]        table_index,
	input  logic [15:0]       table_value,
	input  logic [11:0]       row,
	input  logic [11:0]       col,
	input  logic [15:0]       pathloss,
	input  logic [19:0]       elevation,
	input  logic              elevation_null,
	output logic              out_v,
	output apl_pkg::apl_geo_t out_d
);

	logic v_s1, v_s2, v_s3, v_s4;

	apl_pkg::apl_tag_t  tag_s1, tag_s2, tag_s3, tag_s4;
	logic [27:0]        pc_s1, pr_s1;
	logic [24:0]        hgt_s1, hgt_s2, hgt_s3, hgt_s4;
	logic signed [33:0] de_s2, dn_s2;
	logic [24:0]        de_s3, dn_s3, de_s4, dn_s4;
	logic [23:0]        ae_s3, an_s3;
	logic [47:0]        se_s4, sn_s4, rr_s4;

	apl_pkg::apl_tag_t  tag_c;
	apl_pkg::apl_tag_t  tag3_c, otag_c;
	logic [27:0]        pc_c, pr_c;
	logic signed [20:0] hdiff_c;
	logic signed [33:0] de_c, dn_c, ae_c, an_c;
	logic               far_c;
	logic [48:0]        dsq_c;

	always_comb begin
		tag_c.kind = kind;
		tag_c.tidx = table_index;
		tag_c.tval = table_value;
		tag_c.pl   = pathloss;
		tag_c.nd   = elevation_null || (32'(row) >= 32'(apl_pkg::MAX_DIM))
			|| (32'(col) >= 32'(apl_pkg::MAX_DIM));
		pc_c    = col * cfg.col_step;
		pr_c    = row * cfg.row_step;
		hdiff_c = $signed({cfg.height_offset[19], cfg.height_offset})
			- $signed({elevation[19], elevation});
	end

	always_comb begin
		de_c = $signed({6'b0, pc_s1})
			- $signed({{2{cfg.east_offset[31]}}, cfg.east_offset});
		dn_c = $signed({{2{cfg.north_offset[31]}}, cfg.north_offset})
			- $signed({6'b0, pr_s1});
	end

	always_comb begin
		ae_c  = de_s2[33] ? -de_s2 : de_s2;
		an_c  = dn_s2[33] ? -dn_s2 : dn_s2;
		far_c = (ae_c > $signed({10'b0, cfg.radius})) || (an_c > $signed({10'b0, cfg.radius}));
	end

	assign dsq_c = {1'b0, se_s4} + {1'b0, sn_s4};

	// Fold the radius tests into the no-data flag
	always_comb begin
		tag3_c    = tag_s2;
		tag3_c.nd = tag_s2.nd || far_c;
		otag_c    = tag_s4;
		otag_c.nd = tag_s4.nd || (dsq_c > {1'b0, rr_s4});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			out_v <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= tag_c;
			pc_s1  <= pc_c;
			pr_s1  <= pr_c;
			hgt_s1 <= {hdiff_c, 4'b0000};

			tag_s2 <= tag_s1;
			de_s2  <= de_c;
			dn_s2  <= dn_c;
			hgt_s2 <= hgt_s1;

			tag_s3 <= tag3_c;
			de_s3  <= de_s2[24:0];
			dn_s3  <= dn_s2[24:0];
			ae_s3  <= ae_c[23:0];
			an_s3  <= an_c[23:0];
			hgt_s3 <= hgt_s2;

			tag_s4 <= tag_s3;
			de_s4  <= de_s3;
			dn_s4  <= dn_s3;
			se_s4  <= ae_s3 * ae_s3;
			sn_s4  <= an_s3 * an_s3;
			rr_s4  <= cfg.radius * cfg.radius;
			hgt_s4 <= hgt_s3;

			out_d.tag <= otag_c;
			out_d.de  <= de_s4;
			out_d.dn  <= dn_s4;
			out_d.dsq <= dsq_c[47:0];
			out_d.hgt <= hgt_s4;
		end
	end

endmodule

>>> rtl/core/apl_mid.sv
// Distance root and bearing rotation side by side, then the angle off the beam.
module apl_mid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  apl_pkg::apl_cfg_t cfg,
	input  logic              in_v,
	input  apl_pkg::apl_geo_t in_d,
	output logic              out_v,
	output apl_pkg::apl_ang_t out_d
);

	localparam int NS = apl_pkg::SQ_STAGES;

	typedef struct packed {
		apl_pkg::apl_tag_t               tag;
		logic signed [apl_pkg::CX_W-1:0] x;
		logic signed [apl_pkg::CX_W-1:0] y;
		logic signed [apl_pkg::Z_W-1:0]  z;
		logic                            sp;
		logic [apl_pkg::ANG_W-1:0]       spa;
		logic [apl_pkg::SQ_W-1:0]        v;
		logic [apl_pkg::SQ_W-1:0]        r;
		logic [24:0]                     hgt;
	} mid_st_t;

	mid_st_t st_s [NS+1];
	logic    vld_s [NS+1];

	mid_st_t                   ent_c;
	logic signed [apl_pkg::CX_W-1:0] dn_x, de_x;

	logic                      fv_s1;
	apl_pkg::apl_tag_t         ftag_s1;
	logic [apl_pkg::ANG_W-1:0] brg_s1;
	logic [27:0]               rng_s1;
	logic [24:0]               hgt_s1;
	logic [8:0]                beam_c;
	logic signed [19:0]        hd_raw_c;

	always_comb begin
		ent_c     = '0;
		ent_c.tag = in_d.tag;
		ent_c.hgt = in_d.hgt;
		ent_c.v   = {in_d.dsq, 8'b0};
		ent_c.r   = '0;
		dn_x      = apl_pkg::CX_W'($signed(in_d.dn));
		de_x      = apl_pkg::CX_W'($signed(in_d.de));
		// Bearing of a point on an axis, or of the transmitter cell itself
		if (in_d.de == '0 && in_d.dn == '0) begin
			ent_c.sp  = 1'b1;
			ent_c.spa = apl_pkg::QUARTER;
		end else if (in_d.de == '0) begin
			ent_c.sp  = 1'b1;
			ent_c.spa = in_d.dn[24] ? apl_pkg::HALF_TURN : '0;
		end else if (in_d.dn == '0) begin
			ent_c.sp  = 1'b1;
			ent_c.spa = in_d.de[24] ? (apl_pkg::TURN - apl_pkg::QUARTER) : apl_pkg::QUARTER;
		end
		// Rotate the left half plane by half a turn
		if (in_d.dn[24]) begin
			ent_c.x = -dn_x;
			ent_c.y = -de_x;
			ent_c.z = apl_pkg::Z_HALF;
		end else begin
			ent_c.x = dn_x;
			ent_c.y = de_x;
			ent_c.z = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= ent_c;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_stage
		localparam logic [apl_pkg::SQ_W-1:0] BIT = apl_pkg::SQ_W'(1) << (2 * (NS - 1 - k));
		localparam bit ROT = (k < apl_pkg::CORDIC_STAGES);

		mid_st_t                         nxt;
		logic signed [apl_pkg::CX_W-1:0] xs, ys;
		logic [apl_pkg::SQ_W:0]          trial;

		always_comb begin
			nxt   = st_s[k];
			trial = {1'b0, st_s[k].r} + {1'b0, BIT};
			if ({1'b0, st_s[k].v} >= trial) begin
				nxt.v = st_s[k].v - trial[apl_pkg::SQ_W-1:0];
				nxt.r = (st_s[k].r >> 1) + BIT;
			end else begin
				nxt.r = st_s[k].r >> 1;
			end
			xs = $signed(st_s[k].x) >>> k;
			ys = $signed(st_s[k].y) >>> k;
			if (ROT) begin
				if ($signed(st_s[k].y) > 0) begin
					nxt.x = st_s[k].x + ys;
					nxt.y = st_s[k].y - xs;
					nxt.z = st_s[k].z + apl_pkg::atan_lut(k);
				end else begin
					nxt.x = st_s[k].x - ys;
					nxt.y = st_s[k].y + xs;
					nxt.z = st_s[k].z - apl_pkg::atan_lut(k);
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k+1] <= nxt;
			end
		end
	end

	always_comb begin
		beam_c   = (cfg.azimuth >= 9'd360) ? (cfg.azimuth - 9'd360)
			: cfg.azimuth;
		hd_raw_c = $signed({3'b000, brg_s1}) - $signed({3'b000, beam_c, 8'b0});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fv_s1 <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			fv_s1 <= vld_s[NS];
			out_v <= fv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ftag_s1 <= st_s[NS].tag;
			brg_s1  <= st_s[NS].sp ? st_s[NS].spa
				: apl_pkg::angle_wrap(apl_pkg::z_round(st_s[NS].z));
			rng_s1  <= st_s[NS].r[27:0];
			hgt_s1  <= st_s[NS].hgt;

			out_d.tag <= ftag_s1;
			out_d.hd  <= apl_pkg::angle_wrap(hd_raw_c);
			out_d.rng <= rng_s1;
			out_d.hgt <= hgt_s1;
		end
	end

endmodule

>>> rtl/core/apl_elev.sv
// Elevation angle rotation, bearing-dependent tilt and the vertical diagram angle.
module apl_elev (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  apl_pkg::apl_cfg_t cfg,
	input  logic              in_v,
	input  apl_pkg::apl_ang_t in_d,
	output logic              out_v,
	output apl_pkg::apl_vd_t  out_d
);

	localparam int NC = apl_pkg::CORDIC_STAGES;

	typedef struct packed {
		apl_pkg::apl_tag_t               tag;
		logic [apl_pkg::ANG_W-1:0]       hd;
		logic signed [apl_pkg::EX_W-1:0] x;
		logic signed [apl_pkg::EX_W-1:0] y;
		logic signed [apl_pkg::Z_W-1:0]  z;
		logic                            sp;
		logic [apl_pkg::ANG_W-1:0]       spa;
	} elev_st_t;

	typedef struct packed {
		apl_pkg::apl_tag_t         tag;
		logic [apl_pkg::ANG_W-1:0] hd;
		logic [apl_pkg::ANG_W-1:0] va;
	} elev_tag_t;

	elev_st_t st_s [NC+1];
	logic     vld_s [NC+1];
	elev_st_t ent_c;

	logic               tv_s1, tv_s2, tv_s3, tv_s4;
	elev_tag_t          tt_s1, tt_s2, tt_s3, tt_s4;
	logic signed [25:0] n_s1;
	logic [20:0]        a_s2, a_s3;
	logic               neg_s2, neg_s3;
	logic [14:0]        q0_s3;
	logic signed [15:0] tc_s4;

	elev_tag_t          tt_c;
	logic signed [17:0] d_c;
	logic signed [25:0] tilt_c, n_c, nabs_c;
	logic [42:0]        p_c;
	logic [21:0]        q90_c, rem_c;
	logic [15:0]        q_c;

	always_comb begin
		ent_c     = '0;
		ent_c.tag = in_d.tag;
		ent_c.hd  = in_d.hd;
		ent_c.x   = $signed({3'b000, in_d.rng});
		ent_c.y   = $signed({{6{in_d.hgt[24]}}, in_d.hgt});
		ent_c.z   = '0;
		// Straight overhead, or level with the transmitter
		if (in_d.rng == '0) begin
			ent_c.sp  = 1'b1;
			ent_c.spa = apl_pkg::QUARTER;
		end else if (in_d.hgt == '0) begin
			ent_c.sp  = 1'b1;
			ent_c.spa = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_s[0] <= ent_c;
		end
	end

	for (genvar k = 0; k < NC; k++) begin : g_stage
		elev_st_t                        nxt;
		logic signed [apl_pkg::EX_W-1:0] xs, ys;

		always_comb begin
			nxt = st_s[k];
			xs  = $signed(st_s[k].x) >>> k;
			ys  = $signed(st_s[k].y) >>> k;
			if ($signed(st_s[k].y) > 0) begin
				nxt.x = st_s[k].x + ys;
				nxt.y = st_s[k].y - xs;
				nxt.z = st_s[k].z + apl_pkg::atan_lut(k);
			end else begin
				nxt.x = st_s[k].x - ys;
				nxt.y = st_s[k].y + xs;
				nxt.z = st_s[k].z - apl_pkg::atan_lut(k);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				st_s[k+1] <= nxt;
			end
		end
	end

	// Tilt numerator: tilt times the signed distance of the bearing from the side lobes
	always_comb begin
		tt_c.tag = st_s[NC].tag;
		tt_c.hd  = st_s[NC].hd;
		tt_c.va  = st_s[NC].sp ? st_s[NC].spa
			: apl_pkg::angle_wrap(apl_pkg::z_round(st_s[NC].z));
		if (st_s[NC].hd <= apl_pkg::HALF_TURN) begin
			d_c = $signed({1'b0, apl_pkg::QUARTER}) - $signed({1'b0, st_s[NC].hd});
		end else begin
			d_c = $signed({1'b0, st_s[NC].hd}) - $signed({1'b0, apl_pkg::THREE_QUARTER});
		end
		tilt_c = $signed({{18{cfg.downtilt[7]}}, cfg.downtilt});
		n_c    = tilt_c * $signed({{8{d_c[17]}}, d_c});
	end

	// Divide by 90 through the reciprocal, then fix the quotient by one
	always_comb begin
		nabs_c = n_s1[25] ? -n_s1 : n_s1;
		p_c    = a_s2 * apl_pkg::DIV90_M;
		q90_c  = q0_s3 * 22'd90;
		rem_c  = {1'b0, a_s3} - q90_c;
		q_c    = (rem_c >= 22'd90) ? ({1'b0, q0_s3} + 16'd1) : {1'b0, q0_s3};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_s1 <= 1'b0;
			tv_s2 <= 1'b0;
			tv_s3 <= 1'b0;
			tv_s4 <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			tv_s1 <= vld_s[NC];
			tv_s2 <= tv_s1;
			tv_s3 <= tv_s2;
			tv_s4 <= tv_s3;
			out_v <= tv_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tt_s1 <= tt_c;
			n_s1  <= n_c;

			tt_s2  <= tt_s1;
			a_s2   <= nabs_c[20:0] + 21'd45;
			neg_s2 <= n_s1[25];

			tt_s3  <= tt_s2;
			a_s3   <= a_s2;
			neg_s3 <= neg_s2;
			q0_s3  <= p_c[apl_pkg::DIV90_SH+14:apl_pkg::DIV90_SH];

			tt_s4 <= tt_s3;
			tc_s4 <= neg_s3 ? $signed(16'd0 - q_c) : $signed(q_c);

			out_d.tag <= tt_s4.tag;
			out_d.hd  <= tt_s4.hd;
			out_d.vd  <= apl_pkg::angle_wrap($signed({3'b000, tt_s4.va})
				- $signed({{4{tc_s4[15]}}, tc_s4}));
		end
	end

endmodule

>>> rtl/core/apl_table.sv
// Diagram tables, their loads, interpolated lookups and the saturating loss sum.
module apl_table (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_v,
	input  apl_pkg::apl_vd_t in_d,
	output logic             out_v,
	output apl_pkg::apl_res_t out_d
);

	logic [15:0] htab_q [apl_pkg::TBL_DEPTH];
	logic [15:0] vtab_q [apl_pkg::TBL_DEPTH];

	logic              v_s1, v_s2;
	apl_pkg::apl_tag_t tag_s1, tag_s2;
	logic [15:0]       h0_s1, h1_s1, w0_s1, w1_s1;
	logic [7:0]        hf_s1, vf_s1;
	logic signed [25:0] hl_s2, vl_s2;

	logic [apl_pkg::TBL_AW-1:0] hi_c, hn_c, vi_c, vn_c;
	logic                       ld_ok_c;
	logic signed [16:0]         hdf_c, vdf_c;
	logic signed [25:0]         hl_c, vl_c;
	logic signed [26:0]         sum_c;
	logic signed [26:0]         rnd_c;
	logic [17:0]                loss_c;

	function automatic logic [apl_pkg::TBL_AW-1:0] idx_of(input logic [apl_pkg::ANG_W-1:0] a);
		logic [apl_pkg::TBL_AW-1:0] i;
		i = a[apl_pkg::ANG_W-1:8];
		return (32'(i) >= 32'(apl_pkg::TBL_DEPTH)) ? '0 : i;
	endfunction

	function automatic logic [apl_pkg::TBL_AW-1:0] next_of(input logic [apl_pkg::TBL_AW-1:0] i);
		return (32'(i) == 32'(apl_pkg::TBL_DEPTH - 1)) ? '0 : (i + 1'b1);
	endfunction

	always_comb begin
		hi_c    = idx_of(in_d.hd);
		hn_c    = next_of(hi_c);
		vi_c    = idx_of(in_d.vd);
		vn_c    = next_of(vi_c);
		ld_ok_c = in_v && (32'(in_d.tag.tidx) < 32'(apl_pkg::TBL_DEPTH));
	end

	// Loads and lookups meet here in arrival order, so a load lands before any later pixel
	always_ff @(posedge clk) begin
		if (en) begin
			if (ld_ok_c && in_d.tag.kind == apl_pkg::KIND_LOAD_H) begin
				htab_q[in_d.tag.tidx] <= in_d.tag.tval;
			end
			if (ld_ok_c && in_d.tag.kind == apl_pkg::KIND_LOAD_V) begin
				vtab_q[in_d.tag.tidx] <= in_d.tag.tval;
			end
			h0_s1 <= htab_q[hi_c];
			h1_s1 <= htab_q[hn_c];
			w0_s1 <= vtab_q[vi_c];
			w1_s1 <= vtab_q[vn_c];
		end
	end

	always_comb begin
		hdf_c = $signed({h1_s1[15], h1_s1}) - $signed({h0_s1[15], h0_s1});
		vdf_c = $signed({w1_s1[15], w1_s1}) - $signed({w0_s1[15], w0_s1});
		hl_c  = $signed({{2{h0_s1[15]}}, h0_s1, 8'b0})
			+ ($signed({{9{hdf_c[16]}}, hdf_c}) * $signed({18'b0, hf_s1}));
		vl_c  = $signed({{2{w0_s1[15]}}, w0_s1, 8'b0})
			+ ($signed({{9{vdf_c[16]}}, vdf_c}) * $signed({18'b0, vf_s1}));
	end

	always_comb begin
		sum_c = $signed({{3{tag_s2.pl[15]}}, tag_s2.pl, 8'b0})
			+ $signed({hl_s2[25], hl_s2}) + $signed({vl_s2[25], vl_s2});
		rnd_c = (sum_c + 27'sd128) >>> 8;
		if (rnd_c > 27'sd131071) begin
			loss_c = 18'h1FFFF;
		end else if (rnd_c < -27'sd131072) begin
			loss_c = 18'h20000;
		end else begin
			loss_c = rnd_c[17:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			out_v <= 1'b0;
		end else if (en) begin
			v_s1  <= in_v;
			v_s2  <= v_s1;
			out_v <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_s1 <= in_d.tag;
			hf_s1  <= in_d.hd[7:0];
			vf_s1  <= in_d.vd[7:0];

			tag_s2 <= tag_s1;
			hl_s2  <= hl_c;
			vl_s2  <= vl_c;

			out_d.kind <= tag_s2.kind;
			out_d.nd   <= tag_s2.nd;
			out_d.loss <= loss_c;
		end
	end

endmodule

>>> rtl/core/antenna_pattern_loss_map.sv
// Top level of the antenna pattern loss map: configuration, pipeline and result register.
//
// Streams raster words through a pipeline with 16 rotation stages and takes one word per
// clock whenever the result register is empty or being taken, so a stall on the result
// side freezes every stage at once and nothing is lost or repeated. A pixel word gives one
// result: its pathloss plus the interpolated horizontal and vertical diagram losses in
// 1/64 dB, or no_data with a zero loss when the elevation is null, the cell lies outside
// the radius or the row or column is out of range.
// Load words (kind 0 horizontal, kind 1 vertical) write a table entry and give no result;
// indexes of 360 and up are dropped, as is kind 3. The tables have no reset, so every entry a
// pixel can touch must be loaded first, and the antenna gain belongs in the horizontal entries.
// The latency is set by the distance root, which retires one bit per stage over 28 stages,
// followed by the elevation rotation and the tilt division. Write configuration only while no
// words are in flight.
module antenna_pattern_loss_map (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        pix_valid,
	output logic        pix_ready,
	input  logic [1:0]  kind,
	input  logic [8:0]  table_index,
	input  logic [15:0] table_value,
	input  logic [11:0] row,
	input  logic [11:0] col,
	input  logic [15:0] pathloss,
	input  logic [19:0] elevation,
	input  logic        elevation_null,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [17:0] total_loss,
	output logic        no_data
);

	apl_pkg::apl_cfg_t cfg_q;

	logic              en;
	logic              geo_v, ang_v, vd_v, tab_v;
	apl_pkg::apl_geo_t geo_d;
	apl_pkg::apl_ang_t ang_d;
	apl_pkg::apl_vd_t  vd_d;
	apl_pkg::apl_res_t tab_d;

	logic        res_valid_q;
	logic [17:0] total_loss_q;
	logic        no_data_q;

	// Advance the whole pipeline unless a finished word waits in the result register
	assign en        = !res_valid_q || res_ready;
	assign pix_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.east_offset   <= '0;
			cfg_q.north_offset  <= '0;
			cfg_q.col_step      <= 16'd16;
			cfg_q.row_step      <= 16'd16;
			cfg_q.radius        <= 24'd160000;
			cfg_q.height_offset <= '0;
			cfg_q.azimuth       <= '0;
			cfg_q.downtilt      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				apl_pkg::CFG_EAST_OFFSET:   cfg_q.east_offset   <= cfg_data;
				apl_pkg::CFG_NORTH_OFFSET:  cfg_q.north_offset  <= cfg_data;
				apl_pkg::CFG_COL_STEP:      cfg_q.col_step      <= cfg_data[15:0];
				apl_pkg::CFG_ROW_STEP:      cfg_q.row_step      <= cfg_data[15:0];
				apl_pkg::CFG_RADIUS:        cfg_q.radius        <= cfg_data[23:0];
				apl_pkg::CFG_HEIGHT_OFFSET: cfg_q.height_offset <= cfg_data[19:0];
				apl_pkg::CFG_AZIMUTH:       cfg_q.azimuth       <= cfg_data[8:0];
				apl_pkg::CFG_DOWNTILT:      cfg_q.downtilt      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	apl_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.cfg            (cfg_q),
		.in_v           (pix_valid && en),
		.kind           (kind),
		.table_index    (table_index),
		.table_value    (table_value),
		.row            (row),
		.col            (col),
		.pathloss       (pathloss),
		.elevation      (elevation),
		.elevation_null (elevation_null),
		.out_v          (geo_v),
		.out_d          (geo_d)
	);

	apl_mid u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cfg    (cfg_q),
		.in_v   (geo_v),
		.in_d   (geo_d),
		.out_v  (ang_v),
		.out_d  (ang_d)
	);

	apl_elev u_elev (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.cfg    (cfg_q),
		.in_v   (ang_v),
		.in_d   (ang_d),
		.out_v  (vd_v),
		.out_d  (vd_d)
	);

	apl_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.in_v   (vd_v),
		.in_d   (vd_d),
		.out_v  (tab_v),
		.out_d  (tab_d)
	);

	// Only pixel words leave the block; drop loads and unknown kinds here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= tab_v && (tab_d.kind == apl_pkg::KIND_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			total_loss_q <= tab_d.nd ? '0 : tab_d.loss;
			no_data_q    <= tab_d.nd;
		end
	end

	assign res_valid  = res_valid_q;
	assign total_loss = total_loss_q;
	assign no_data    = no_data_q;

endmodule

>>> rtl/core/apl_checker.sv
// Port-level checks of the antenna pattern loss map, bound to the top level.
module apl_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_valid,
	input logic        pix_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [17:0] total_loss,
	input logic        no_data
);

	// A waiting result holds its word
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(total_loss) && $stable(no_data))
		else $error("result word changed while stalled");

	// A result leaves only when taken
	a_res_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(res_valid) |-> $past(res_ready))
		else $error("result word dropped without handshake");

	// No-data words carry a zero loss
	a_nodata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && no_data |-> total_loss == 18'd0)
		else $error("no-data word with nonzero loss");

	// An empty result register never blocks the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> pix_ready)
		else $error("input stalled with empty result register");

	// A stalled result side stalls the input as well
	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |-> !pix_ready || !pix_valid || pix_ready == 1'b0)
		else $error("input taken while result side stalled");

endmodule

bind antenna_pattern_loss_map apl_checker u_apl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_valid  (pix_valid),
	.pix_ready  (pix_ready),
	.res_valid  (res_valid),
	.res_ready  (res_ready),
	.total_loss (total_loss),
	.no_data    (no_data)
);
